// ===== design/slwp_pkg.sv =====
// ----------------------------------------------------------------------------
// slwp_pkg - shared types and constants for the windowed PID speed loop
// Data widths, register index codes and parameter defaults.
// ----------------------------------------------------------------------------
package slwp_pkg;

    // Q16.16 data word and unsigned limit registers
    localparam int DATA_W    = 32;
    localparam int LIMIT_W   = 31;
    localparam int CFG_IDX_W = 3;

    // defaults for the top-level parameters
    localparam int WINDOW_DEF    = 12;
    localparam int FRAC_BITS_DEF = 16;

    // slope term 3*e0 - 4*e1 + e2 needs three bits of headroom
    localparam int SLOPE_W = DATA_W + 3;

    // full-scale limit reset value
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_DEMAND_LIMIT = 3'd3,
        CFG_ERROR_LIMIT  = 3'd4,
        CFG_OUTPUT_LIMIT = 3'd5
    } cfg_reg_t;

endpackage

// ===== design/speed_loop_windowed_pid.sv =====
// ----------------------------------------------------------------------------
// speed_loop_windowed_pid - incremental PID speed controller, windowed I term
// One control tick per input word: clamp, error, P/I/D terms, output clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready) carries one tick: demand, measured
//   speed (signed Q16.16) and a clear flag. Output channel
//   (result_valid/result_ready) returns one drive word per tick.
//   Gains and limits are written through cfg_wr_en/cfg_index/cfg_data while
//   the loop is idle; a write takes effect at the clock edge, unknown indexes
//   are dropped.
// Pipeline / throughput:
//   The tick is captured in an input register, the whole update (error
//   clamp, three multiplies, sum, output clamp) runs in one pass into the
//   result register, and result_valid rises when that register is loaded.
//   One tick per cycle sustained while result_ready stays high; the loop
//   state (error history, window sum, last_drive) feeds back into the pass.
// Reset:
//   Gains go to zero, demand/output limits to full scale, error limit to 2.0.
//   Error history, window sum and last drive are zeroed. A tick with clear
//   set does the same to the loop state and returns a zero drive.
// Stall:
//   While a result waits for result_ready, the input register still takes
//   one more word; after that item_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module speed_loop_windowed_pid
#(
    parameter int WINDOW    = slwp_pkg::WINDOW_DEF,
    parameter int FRAC_BITS = slwp_pkg::FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [slwp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [slwp_pkg::DATA_W-1:0]         cfg_data,
    // tick input
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic signed [slwp_pkg::DATA_W-1:0]  demand,
    input  logic signed [slwp_pkg::DATA_W-1:0]  measured,
    input  logic                                clear,
    // drive output
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [slwp_pkg::DATA_W-1:0]  drive
);

    import slwp_pkg::*;

    // window sum holds up to WINDOW errors
    localparam int SUM_W  = DATA_W + $clog2(WINDOW);
    localparam int HIST_N = WINDOW - 1;
    // wide accumulator: covers the largest product plus carries
    localparam int ACC_W  = DATA_W + SUM_W + 2;
    localparam logic [LIMIT_W-1:0] ERR_LIMIT_RST = LIMIT_W'(2) << FRAC_BITS;

    // ---------------- configuration registers ----------------
    logic signed [DATA_W-1:0]  prop_gain_reg;
    logic signed [DATA_W-1:0]  integ_gain_reg;
    logic signed [DATA_W-1:0]  deriv_gain_reg;
    logic [LIMIT_W-1:0]        demand_limit_reg;
    logic [LIMIT_W-1:0]        error_limit_reg;
    logic [LIMIT_W-1:0]        output_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            demand_limit_reg <= LIMIT_MAX;
            error_limit_reg  <= ERR_LIMIT_RST;
            output_limit_reg <= LIMIT_MAX;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                CFG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data;
                CFG_DEMAND_LIMIT: demand_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_ERROR_LIMIT:  error_limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_OUTPUT_LIMIT: output_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic in_valid_reg;
    logic result_valid_reg;
    logic stall;
    logic fire;

    // result held and not taken: the pass cannot advance
    assign stall      = result_valid_reg && !result_ready;
    assign item_ready = !in_valid_reg || !stall;
    assign fire       = in_valid_reg && !stall;

    // ---------------- input register ----------------
    logic signed [DATA_W-1:0] demand_reg;
    logic signed [DATA_W-1:0] measured_reg;
    logic                     clear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            demand_reg   <= demand;
            measured_reg <= measured;
            clear_reg    <= clear;
        end
    end

    // ---------------- loop state ----------------
    logic signed [DATA_W-1:0] hist_reg [HIST_N];   // e1 .. e(WINDOW-1)
    logic signed [SUM_W-1:0]  window_sum_reg;      // sum of hist_reg
    logic signed [DATA_W-1:0] last_drive_reg;

    // ---------------- single pass ----------------
    logic signed [DATA_W-1:0]        dem_lim;
    logic signed [DATA_W-1:0]        dem_clamped;
    logic signed [DATA_W:0]          err_raw;
    logic signed [DATA_W:0]          err_lim;
    logic signed [DATA_W-1:0]        e0;
    logic signed [SUM_W-1:0]         integ;
    logic signed [SLOPE_W-1:0]       slope;
    logic signed [2*DATA_W-1:0]      prod_p;
    logic signed [DATA_W+SUM_W-1:0]  prod_i;
    logic signed [DATA_W+SLOPE_W-1:0] prod_d;
    logic signed [ACC_W-1:0]         acc;
    logic signed [ACC_W-1:0]         out_lim;
    logic signed [DATA_W-1:0]        drive_next;
    logic signed [SUM_W-1:0]         window_sum_next;

    always_comb
    begin
        // demand clamp, inclusive
        dem_lim = $signed({1'b0, demand_limit_reg});
        if (demand_reg > dem_lim)
            dem_clamped = dem_lim;
        else if (demand_reg < -dem_lim)
            dem_clamped = -dem_lim;
        else
            dem_clamped = demand_reg;

        // error formed one bit wider so it never wraps
        err_raw = (DATA_W+1)'(dem_clamped) - (DATA_W+1)'(measured_reg);
        err_lim = $signed({2'b00, error_limit_reg});
        if (err_raw > err_lim)
            e0 = DATA_W'(err_lim);
        else if (err_raw < -err_lim)
            e0 = DATA_W'(-err_lim);
        else
            e0 = DATA_W'(err_raw);

        // terms
        integ = window_sum_reg + SUM_W'(e0);
        slope = SLOPE_W'(e0) + (SLOPE_W'(e0) <<< 1)
              - (SLOPE_W'(hist_reg[0]) <<< 2) + SLOPE_W'(hist_reg[1]);

        // exact products; arithmetic shift gives floor
        prod_p = (2*DATA_W)'(prop_gain_reg) * (2*DATA_W)'(e0);
        prod_i = (DATA_W+SUM_W)'(integ_gain_reg) * (DATA_W+SUM_W)'(integ);
        prod_d = (DATA_W+SLOPE_W)'(deriv_gain_reg) * (DATA_W+SLOPE_W)'(slope);

        acc = ACC_W'(last_drive_reg)
            + ACC_W'(prod_p >>> FRAC_BITS)
            + ACC_W'(prod_i >>> FRAC_BITS)
            + ACC_W'(prod_d >>> FRAC_BITS);

        // output clamp, inclusive
        out_lim = ACC_W'($signed({1'b0, output_limit_reg}));
        if (clear_reg)
            drive_next = '0;
        else if (acc > out_lim)
            drive_next = DATA_W'(out_lim);
        else if (acc < -out_lim)
            drive_next = DATA_W'(-out_lim);
        else
            drive_next = DATA_W'(acc);

        // running window: add newest, drop oldest
        window_sum_next = window_sum_reg + SUM_W'(e0) - SUM_W'(hist_reg[HIST_N-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_N; i++)
            begin
                hist_reg[i] <= '0;
            end
            window_sum_reg <= '0;
            last_drive_reg <= '0;
        end
        else if (fire)
        begin
            if (clear_reg)
            begin
                for (int i = 0; i < HIST_N; i++)
                begin
                    hist_reg[i] <= '0;
                end
                window_sum_reg <= '0;
                last_drive_reg <= '0;
            end
            else
            begin
                hist_reg[0] <= e0;
                for (int i = 1; i < HIST_N; i++)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                window_sum_reg <= window_sum_next;
                last_drive_reg <= drive_next;
            end
        end
    end

    // ---------------- result register ----------------
    logic signed [DATA_W-1:0] drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            result_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            drive_reg <= drive_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign drive        = drive_reg;

    // ---------------- assertions ----------------
    // clamped error stays inside the error limit
    a_err_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (e0 <= $signed({1'b0, error_limit_reg}))
              && (e0 >= -$signed({1'b0, error_limit_reg})))
        else $error("error term outside error_limit");

    // a clear tick zeroes the loop state and returns zero drive
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && clear_reg) |=> result_valid_reg && (drive_reg == '0)
                                && (window_sum_reg == '0) && (last_drive_reg == '0))
        else $error("clear tick left nonzero state");

    // the stored drive matches the one presented
    a_drive_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (drive_reg == last_drive_reg))
        else $error("result and last_drive diverged");

endmodule
